// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the table RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SKVT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("table assertion failed");
`define SKVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("table assertion failed");
`define SKVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("table assertion failed");
`else
`define SKVT_ASSERT(lbl, clk, rst_n, prop)
`define SKVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SKVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/skvt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sparse key/value table package
// Shared constants, codes and control types of the table.
// ---------------------------------------------------------------------------
package skvt_pkg;

	localparam int CAPACITY_DEF    = 128;
	localparam int KEY_WIDTH_DEF   = 20;
	localparam int KEY_LIMIT_RESET = 1000000;
	localparam int VALUE_W         = 32;
	localparam int REQ_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int COUNT_OUT_W     = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_DEL    = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_RESOLVE,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic look;
		logic update;
		logic append;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== sv/skvt_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request.
// ---------------------------------------------------------------------------
interface skvt_req_if #(
	parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
);
	logic                                valid;
	logic                                ready;
	logic [skvt_pkg::REQ_W-1:0]          req_type;
	logic [KEY_WIDTH-1:0]                key;
	logic signed [skvt_pkg::VALUE_W-1:0] write_value;

	modport source (output valid, req_type, key, write_value, input ready);
	modport sink (input valid, req_type, key, write_value, output ready);
endinterface

// ===== sv/skvt_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one table response.
// ---------------------------------------------------------------------------
interface skvt_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [skvt_pkg::VALUE_W-1:0] read_value;
	logic [skvt_pkg::STATUS_W-1:0]       status;
	logic [skvt_pkg::COUNT_OUT_W-1:0]    entry_count;

	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

// ===== sv/skvt_cfg_if.sv =====
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the key limit register.
// ---------------------------------------------------------------------------
interface skvt_cfg_if #(
	parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] key_limit;

	modport source (output valid, key_limit, input ready);
	modport sink (input valid, key_limit, output ready);
endinterface

// ===== sv/skvt_cell.sv =====
// ---------------------------------------------------------------------------
// Table cell
// One entry of the table: key, value and match flag, with a shift path from
// the next cell used to close the gap left by a delete.
// ---------------------------------------------------------------------------
module skvt_cell #(
	parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF,
	parameter int IDX       = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  skvt_pkg::cell_ctl_t                   ctl,
	input  logic [KEY_WIDTH-1:0]                  cmp_key,
	input  logic [skvt_pkg::VALUE_W-1:0]          wr_value,
	input  logic [$clog2(CAPACITY+1)-1:0]         count,
	input  logic [$clog2(CAPACITY)-1:0]           slot,
	input  logic [KEY_WIDTH-1:0]                  next_key,
	input  logic [skvt_pkg::VALUE_W-1:0]          next_value,
	output logic [KEY_WIDTH-1:0]                  key,
	output logic [skvt_pkg::VALUE_W-1:0]          value,
	output logic                                  match
);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int SW = $clog2(CAPACITY);

	logic [KEY_WIDTH-1:0]         key_q;
	logic [skvt_pkg::VALUE_W-1:0] value_q;
	logic                         match_q;
	logic                         occupied;
	logic                         shift_en;

	assign occupied = CW'(IDX) < count;
	assign shift_en = ctl.shift && (SW'(IDX) >= slot) && (CW'(IDX + 1) < count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.look) begin
			match_q <= occupied && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && (CW'(IDX) == count)) begin
			key_q   <= cmp_key;
			value_q <= wr_value;
		end else if (ctl.update && match_q) begin
			value_q <= wr_value;
		end else if (shift_en) begin
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = match_q;

endmodule

// ===== sv/sparse_key_value_table.sv =====
// ---------------------------------------------------------------------------
// Sparse key/value table
// A row of key/value cells standing for a large, mostly zero array, with put,
// get and delete requests and a status and entry count on every response.
// ---------------------------------------------------------------------------
// Requests arrive on the req channel and each gives one response on the rsp
// channel; a transfer happens when valid and ready are both high.
// The cfg channel writes the key limit and is always ready; the user must write
// it only while the table is idle, which the block does not enforce. Keys above
// the limit are refused. From its transfer to a valid response a request goes
// through these steps: one in which every cell compares its key with the
// captured one, one to encode the matching cell and read its value, and one to
// update the cells and register the response. The next request is taken in the
// cycle after the response is registered, never while one is in flight.
// If the receiver stalls, a finished response waits in the output register,
// one more request is taken and held in its update step until that slot frees.
// Reset empties the table and sets the key limit to 1000000; cell contents
// are not cleared, as only entries below the count are ever compared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_key_value_table #(
	parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	skvt_req_if.sink    req,
	skvt_rsp_if.source  rsp,
	skvt_cfg_if.sink    cfg
);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int SW = $clog2(CAPACITY);
	localparam int VW = skvt_pkg::VALUE_W;

	skvt_pkg::state_t    state_q, state_d;
	skvt_pkg::cell_ctl_t ctl;

	logic [KEY_WIDTH-1:0]          limit_q;
	logic [skvt_pkg::REQ_W-1:0]    op_q;
	logic [KEY_WIDTH-1:0]          key_q;
	logic [VW-1:0]                 wv_q;
	logic [CW-1:0]                 count_q, count_d;
	logic                          hit_q;
	logic [SW-1:0]                 slot_q, slot_d;
	logic [VW-1:0]                 rd_q, rd_d;

	logic                          out_valid_q;
	logic [VW-1:0]                 out_value_q, out_value_d;
	logic [skvt_pkg::STATUS_W-1:0] out_status_q, out_status_d;
	logic [skvt_pkg::COUNT_OUT_W-1:0] out_count_q;

	logic                          req_fire;
	logic                          commit_go;
	logic                          range_err;

	logic [CAPACITY-1:0]           match;
	logic [KEY_WIDTH-1:0]          cell_key [CAPACITY+1];
	logic [VW-1:0]                 cell_value [CAPACITY+1];

	assign cell_key[CAPACITY]   = '0;
	assign cell_value[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skvt_cell #(
			.CAPACITY  (CAPACITY),
			.KEY_WIDTH (KEY_WIDTH),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_key    (key_q),
			.wr_value   (wv_q),
			.count      (count_q),
			.slot       (slot_q),
			.next_key   (cell_key[i+1]),
			.next_value (cell_value[i+1]),
			.key        (cell_key[i]),
			.value      (cell_value[i]),
			.match      (match[i])
		);
	end

	assign req.ready = (state_q == skvt_pkg::S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign commit_go = (state_q == skvt_pkg::S_COMMIT) && (!out_valid_q || rsp.ready);
	assign range_err = (op_q != skvt_pkg::REQ_UNUSED) && (key_q > limit_q);

	always_comb begin
		slot_d = '0;
		rd_d   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_d = slot_d | (match[i] ? SW'(i) : '0);
			rd_d   = rd_d | (match[i] ? cell_value[i] : '0);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			skvt_pkg::S_IDLE: begin
				if (req_fire) begin
					state_d = skvt_pkg::S_LOOK;
				end
			end
			skvt_pkg::S_LOOK: begin
				state_d = skvt_pkg::S_RESOLVE;
			end
			skvt_pkg::S_RESOLVE: begin
				state_d = skvt_pkg::S_COMMIT;
			end
			skvt_pkg::S_COMMIT: begin
				if (commit_go) begin
					state_d = skvt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skvt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.look     = (state_q == skvt_pkg::S_LOOK);
		count_d      = count_q;
		out_value_d  = '0;
		out_status_d = skvt_pkg::STAT_OK;
		if (range_err) begin
			out_status_d = skvt_pkg::STAT_RANGE;
		end else begin
			case (op_q)
				skvt_pkg::REQ_PUT: begin
					if (hit_q) begin
						ctl.update = commit_go;
					end else if (count_q < CW'(CAPACITY)) begin
						ctl.append = commit_go;
						count_d    = count_q + CW'(1);
					end else begin
						out_status_d = skvt_pkg::STAT_FULL;
					end
				end
				skvt_pkg::REQ_GET: begin
					out_value_d = hit_q ? rd_q : '0;
				end
				skvt_pkg::REQ_DEL: begin
					if (hit_q) begin
						ctl.shift = commit_go;
						count_d   = count_q - CW'(1);
					end
				end
				default: begin
					out_status_d = skvt_pkg::STAT_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skvt_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			limit_q     <= KEY_WIDTH'(skvt_pkg::KEY_LIMIT_RESET);
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.key_limit;
			end
			if (commit_go) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.req_type;
			key_q <= req.key;
			wv_q  <= req.write_value;
		end
		if (state_q == skvt_pkg::S_RESOLVE) begin
			hit_q  <= |match;
			slot_q <= slot_d;
			rd_q   <= rd_d;
		end
		if (commit_go) begin
			out_value_q  <= out_value_d;
			out_status_q <= out_status_d;
			out_count_q  <= skvt_pkg::COUNT_OUT_W'(count_d);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

	`SKVT_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`SKVT_ASSERT_IMP(a_unique_match, clk, arst_n, state_q == skvt_pkg::S_RESOLVE, $onehot0(match))
	`SKVT_ASSERT_NXT(a_count_hold, clk, arst_n, state_q != skvt_pkg::S_COMMIT, $stable(count_q))
	`SKVT_ASSERT_IMP(a_rsp_from_commit, clk, arst_n, $rose(out_valid_q), $past(state_q == skvt_pkg::S_COMMIT))

endmodule
